### rtl/ssi2d_pkg.sv
package ssi2d_pkg;

  localparam int COORD_W = 16;
  localparam int FRAC_W  = 16;
  localparam int DIFF_W  = COORD_W + 1;
  localparam int PROD_W  = 2 * DIFF_W;
  localparam int AREA_W  = PROD_W + 4;
  localparam int MUL_W   = FRAC_W + DIFF_W + 1;
  localparam int NDIFF   = 12;
  localparam int NPROD   = 6;

  typedef logic signed [COORD_W-1:0] coord_t;
  typedef logic signed [DIFF_W-1:0]  diff_t;
  typedef logic signed [PROD_W-1:0]  prod_t;
  typedef logic signed [AREA_W-1:0]  area_t;
  typedef logic        [AREA_W-1:0]  mag_t;
  typedef logic        [FRAC_W-1:0]  frac_t;
  typedef logic signed [MUL_W-1:0]   mul_t;

  typedef struct packed {
    coord_t ax;
    coord_t ay;
    diff_t  ux;
    diff_t  uy;
  } geom_t;

  function automatic logic opposite(input area_t u, input area_t v);
    logic nz;
    nz = (u != '0) && (v != '0);
    return nz && (u[AREA_W-1] != v[AREA_W-1]);
  endfunction

  function automatic mag_t magnitude(input area_t a);
    area_t n;
    n = -a;
    return a[AREA_W-1] ? mag_t'(n) : mag_t'(a);
  endfunction

endpackage

### rtl/ssi2d_seg_if.sv
interface ssi2d_seg_if;
  import ssi2d_pkg::*;

  logic   valid;
  logic   ready;
  coord_t seg_ab_start_x;
  coord_t seg_ab_start_y;
  coord_t seg_ab_end_x;
  coord_t seg_ab_end_y;
  coord_t seg_cd_start_x;
  coord_t seg_cd_start_y;
  coord_t seg_cd_end_x;
  coord_t seg_cd_end_y;

  modport source (
    output valid, seg_ab_start_x, seg_ab_start_y, seg_ab_end_x, seg_ab_end_y,
    output seg_cd_start_x, seg_cd_start_y, seg_cd_end_x, seg_cd_end_y,
    input  ready
  );
  modport sink (
    input  valid, seg_ab_start_x, seg_ab_start_y, seg_ab_end_x, seg_ab_end_y,
    input  seg_cd_start_x, seg_cd_start_y, seg_cd_end_x, seg_cd_end_y,
    output ready
  );
endinterface

### rtl/ssi2d_hit_if.sv
interface ssi2d_hit_if;
  import ssi2d_pkg::*;

  logic   valid;
  logic   ready;
  logic   crossing;
  frac_t  position_along_ab;
  coord_t cross_x;
  coord_t cross_y;

  modport source (
    output valid, crossing, position_along_ab, cross_x, cross_y,
    input  ready
  );
  modport sink (
    input  valid, crossing, position_along_ab, cross_x, cross_y,
    output ready
  );
endinterface

### rtl/segment_segment_intersect_2d.sv
// Proper-crossing test for two 2D segments AB and CD given in signed Q8.8.
// One segment pair can be transferred in every cycle in which the pipeline
// does not hold, and each produces one result: three stages form the
// coordinate differences, products and triangle areas, one stage makes the
// sign tests and divider operands, sixteen stages of a restoring divider
// each settle one bit of t, and two stages scale the direction of AB by t
// and add A. When the result side holds off a transfer the whole pipeline
// holds, and it resumes with nothing lost. Touching, collinear and
// degenerate cases report no crossing and all-zero fields.
module segment_segment_intersect_2d
  import ssi2d_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  ssi2d_seg_if.sink   in_i,
  ssi2d_hit_if.source out_o
);

  logic en;

  logic  v1_q;
  diff_t d1_q [NDIFF];
  diff_t d1_d [NDIFF];
  geom_t g1_q, g1_d;

  logic  v2_q;
  prod_t p2_q [NPROD];
  geom_t g2_q;

  logic  v3_q;
  area_t a1_3_q, a2_3_q, a3_3_q;
  geom_t g3_q;

  logic  dv_q  [FRAC_W+1];
  logic  dh_q  [FRAC_W+1];
  mag_t  rem_q [FRAC_W+1];
  mag_t  den_q [FRAC_W+1];
  frac_t quo_q [FRAC_W+1];
  geom_t dg_q  [FRAC_W+1];

  area_t a4_d;
  logic  hit_d;

  logic  v5_q, h5_q;
  frac_t t5_q;
  mul_t  mx5_q, my5_q;
  coord_t ax5_q, ay5_q;

  logic   vo_q, co_q;
  frac_t  to_q;
  coord_t xo_q, yo_q;

  assign en       = !vo_q || out_o.ready;
  assign in_i.ready = en;

  always_comb begin
    d1_d[0]  = DIFF_W'(in_i.seg_ab_start_x) - DIFF_W'(in_i.seg_cd_end_x);
    d1_d[1]  = DIFF_W'(in_i.seg_ab_end_y)   - DIFF_W'(in_i.seg_cd_end_y);
    d1_d[2]  = DIFF_W'(in_i.seg_ab_start_y) - DIFF_W'(in_i.seg_cd_end_y);
    d1_d[3]  = DIFF_W'(in_i.seg_ab_end_x)   - DIFF_W'(in_i.seg_cd_end_x);
    d1_d[4]  = DIFF_W'(in_i.seg_ab_start_x) - DIFF_W'(in_i.seg_cd_start_x);
    d1_d[5]  = DIFF_W'(in_i.seg_ab_end_y)   - DIFF_W'(in_i.seg_cd_start_y);
    d1_d[6]  = DIFF_W'(in_i.seg_ab_start_y) - DIFF_W'(in_i.seg_cd_start_y);
    d1_d[7]  = DIFF_W'(in_i.seg_ab_end_x)   - DIFF_W'(in_i.seg_cd_start_x);
    d1_d[8]  = DIFF_W'(in_i.seg_cd_start_x) - DIFF_W'(in_i.seg_ab_start_x);
    d1_d[9]  = DIFF_W'(in_i.seg_cd_end_y)   - DIFF_W'(in_i.seg_ab_start_y);
    d1_d[10] = DIFF_W'(in_i.seg_cd_start_y) - DIFF_W'(in_i.seg_ab_start_y);
    d1_d[11] = DIFF_W'(in_i.seg_cd_end_x)   - DIFF_W'(in_i.seg_ab_start_x);
    g1_d.ax  = in_i.seg_ab_start_x;
    g1_d.ay  = in_i.seg_ab_start_y;
    g1_d.ux  = DIFF_W'(in_i.seg_ab_end_x) - DIFF_W'(in_i.seg_ab_start_x);
    g1_d.uy  = DIFF_W'(in_i.seg_ab_end_y) - DIFF_W'(in_i.seg_ab_start_y);
  end

  assign a4_d  = a3_3_q + a2_3_q - a1_3_q;
  assign hit_d = opposite(a1_3_q, a2_3_q) && opposite(a3_3_q, a4_d);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
      v3_q <= 1'b0;
      for (int k = 0; k <= FRAC_W; k++) begin
        dv_q[k] <= 1'b0;
      end
      v5_q <= 1'b0;
      vo_q <= 1'b0;
    end else if (en) begin
      v1_q <= in_i.valid;
      v2_q <= v1_q;
      v3_q <= v2_q;
      dv_q[0] <= v3_q;
      for (int k = 0; k < FRAC_W; k++) begin
        dv_q[k+1] <= dv_q[k];
      end
      v5_q <= dv_q[FRAC_W];
      vo_q <= v5_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      for (int i = 0; i < NDIFF; i++) begin
        d1_q[i] <= d1_d[i];
      end
      g1_q <= g1_d;

      for (int i = 0; i < NPROD; i++) begin
        p2_q[i] <= PROD_W'(d1_q[2*i]) * PROD_W'(d1_q[2*i+1]);
      end
      g2_q <= g1_q;

      a1_3_q <= AREA_W'(p2_q[0]) - AREA_W'(p2_q[1]);
      a2_3_q <= AREA_W'(p2_q[2]) - AREA_W'(p2_q[3]);
      a3_3_q <= AREA_W'(p2_q[4]) - AREA_W'(p2_q[5]);
      g3_q   <= g2_q;

      dh_q[0]  <= hit_d;
      rem_q[0] <= magnitude(a3_3_q);
      den_q[0] <= magnitude(a3_3_q - a4_d);
      quo_q[0] <= '0;
      dg_q[0]  <= g3_q;

      for (int k = 0; k < FRAC_W; k++) begin
        logic [AREA_W:0] r2;
        logic [AREA_W:0] df;
        r2 = {rem_q[k], 1'b0};
        df = r2 - {1'b0, den_q[k]};
        if (r2 >= {1'b0, den_q[k]}) begin
          rem_q[k+1] <= df[AREA_W-1:0];
          quo_q[k+1] <= {quo_q[k][FRAC_W-2:0], 1'b1};
        end else begin
          rem_q[k+1] <= r2[AREA_W-1:0];
          quo_q[k+1] <= {quo_q[k][FRAC_W-2:0], 1'b0};
        end
        den_q[k+1] <= den_q[k];
        dh_q[k+1]  <= dh_q[k];
        dg_q[k+1]  <= dg_q[k];
      end

      h5_q  <= dh_q[FRAC_W];
      t5_q  <= quo_q[FRAC_W];
      mx5_q <= $signed({1'b0, quo_q[FRAC_W]}) * dg_q[FRAC_W].ux;
      my5_q <= $signed({1'b0, quo_q[FRAC_W]}) * dg_q[FRAC_W].uy;
      ax5_q <= dg_q[FRAC_W].ax;
      ay5_q <= dg_q[FRAC_W].ay;

      co_q <= h5_q;
      to_q <= h5_q ? t5_q : '0;
      xo_q <= h5_q ? coord_t'(ax5_q + mx5_q[FRAC_W +: COORD_W]) : '0;
      yo_q <= h5_q ? coord_t'(ay5_q + my5_q[FRAC_W +: COORD_W]) : '0;
    end
  end

  assign out_o.valid             = vo_q;
  assign out_o.crossing          = co_q;
  assign out_o.position_along_ab = to_q;
  assign out_o.cross_x           = xo_q;
  assign out_o.cross_y           = yo_q;

  a_miss_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    vo_q && !co_q |-> to_q == '0 && xo_q == '0 && yo_q == '0)
    else $error("Miss result carries nonzero fields.");

  a_num_below_den: assert property (@(posedge clk_i) disable iff (!rst_ni)
    dv_q[0] && dh_q[0] |-> rem_q[0] < den_q[0])
    else $error("Crossing with numerator not below denominator.");

  a_rem_below_den: assert property (@(posedge clk_i) disable iff (!rst_ni)
    dv_q[FRAC_W] && dh_q[FRAC_W] |-> rem_q[FRAC_W] < den_q[FRAC_W])
    else $error("Divider remainder out of range.");

endmodule
